// File: hw/rtl/rsss_pkg.sv
// Shared types, codes and helper functions for the random-sample set.
`default_nettype none

package rsss_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned STEP_CNT_W = 5;

    localparam logic [DATA_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic              REG_SEED  = 1'b0;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_RANDOM = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MATCH,
        S_FIND,
        S_DECIDE,
        S_RDLAST,
        S_GATHER,
        S_MOVE,
        S_MOD,
        S_RDPICK,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_MOVE,
        CELL_READ_LAST,
        CELL_READ_SEL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [DATA_W-1:0] query;
        logic [DATA_W-1:0] wr_data;
    } cell_ctrl_t;

    function automatic logic [DATA_W-1:0] lfsr_step(input logic [DATA_W-1:0] s);
        lfsr_step = (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

    function automatic logic [DATA_W-1:0] seed_load(input logic [DATA_W-1:0] s);
        seed_load = (s == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rsss_cell.sv
// One storage cell of the set: an entry, its live flag, a match flag and a read word.
`default_nettype none

module rsss_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rsss_pkg::cell_ctrl_t          ctrl,
    input  wire logic                          sel,
    input  wire logic                          left_live,
    input  wire logic                          right_live,
    output logic                               live,
    output logic                               hit,
    output logic [rsss_pkg::DATA_W-1:0]        rd_word
);
    import rsss_pkg::*;

    logic              live_reg, live_next;
    logic [DATA_W-1:0] entry_reg, entry_next;
    logic              hit_reg, hit_next;
    logic [DATA_W-1:0] rd_word_reg, rd_word_next;
    logic              is_last;

    assign is_last = live_reg && !right_live;

    always_comb begin
        live_next    = live_reg;
        entry_next   = entry_reg;
        rd_word_next = rd_word_reg;
        hit_next     = live_reg && (entry_reg == ctrl.query);
        case (ctrl.cmd)
            CELL_APPEND: begin
                if (!live_reg && left_live) begin
                    live_next  = 1'b1;
                    entry_next = ctrl.wr_data;
                end
            end
            CELL_MOVE: begin
                if (sel) begin
                    entry_next = ctrl.wr_data;
                end
                if (is_last) begin
                    live_next = 1'b0;
                end
            end
            CELL_READ_LAST: begin
                rd_word_next = is_last ? entry_reg : '0;
            end
            CELL_READ_SEL: begin
                rd_word_next = sel ? entry_reg : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
        end else begin
            live_reg <= live_next;
        end
        entry_reg   <= entry_next;
        hit_reg     <= hit_next;
        rd_word_reg <= rd_word_next;
    end

    assign live    = live_reg;
    assign hit     = hit_reg;
    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rsss_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module rsss_rem #(
    parameter int unsigned CW = 7
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rsss_pkg::DATA_W-1:0]   dividend,
    input  wire logic [CW-1:0]                 divisor,
    output logic                               busy,
    output logic [CW-1:0]                      rem
);
    import rsss_pkg::*;

    logic                  busy_reg, busy_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]         div_reg, div_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [CW:0]           cand;

    assign cand = {rem_reg, dvd_reg[DATA_W-1]};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_CNT_W'(DATA_W - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (cand >= {1'b0, div_reg}) begin
                rem_next = CW'(cand - {1'b0, div_reg});
            end else begin
                rem_next = cand[CW-1:0];
            end
            dvd_next = dvd_reg << 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/random_sample_set_swap_remove.sv
// Top level of the random-sample set with swap-remove over a row of storage cells.
//
//  Channel  | Direction | Word contents
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tuser: req_type; tdata: value
//  m_       | out       | tuser: status; tdata: picked_value
//  APB      | in        | register 0 (byte address 0): random_seed
//
// A random pick waits for the bit-serial remainder unit that reduces the LFSR value by
// the count. Searches compare all cells at once into registered match flags, and the
// hit is then gathered into a registered index.
// One request is in flight at a time; a finished word waits in the output register
// while the next request is taken. Reset is synchronous and clears the live flags.
`default_nettype none

module random_sample_set_swap_remove #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // [31:0] value
    input  wire logic [1:0]                    s_tuser,   // [1:0] req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] picked_value
    output logic [1:0]                         m_tuser,   // [1:0] status
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsss_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rsss_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [DATA_W-1:0] query_reg, query_next;
    logic [CW-1:0]     member_count_reg, member_count_next;
    logic [DATA_W-1:0] seed_reg, seed_next;
    logic [DATA_W-1:0] lfsr_reg, lfsr_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] rd_data_reg, rd_data_next;
    status_t           res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_picked_reg, res_picked_next;
    logic              m_tvalid_reg, m_tvalid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_picked_reg, m_picked_next;

    logic              s_accept;
    logic              cfg_wr;
    logic              out_load;
    logic              set_full;
    logic              set_empty;
    logic [DATA_W-1:0] lfsr_stepped;
    logic              div_start;
    logic              div_busy;
    logic [CW-1:0]     div_rem;
    cell_ctrl_t        cell_ctrl;
    logic [IW-1:0]     sel_idx;
    logic              hit_any;
    logic [IW-1:0]     hit_idx;
    logic [DATA_W-1:0] rd_or;

    logic [CAPACITY-1:0] cell_live;
    logic [CAPACITY-1:0] cell_hit;
    logic [DATA_W-1:0]   cell_rd [CAPACITY];

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_W-1:2] == REG_SEED) ? seed_reg : '0;
    assign s_accept  = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_RESP) && (!m_tvalid_reg || m_tready);
    assign set_full  = cell_live[CAPACITY-1];
    assign set_empty = !cell_live[0];
    assign lfsr_stepped = lfsr_step(lfsr_reg);

    // Cell row: each cell sees its neighbours' live flags, so the live flags form a
    // thermometer code and the first free and last live cells find themselves.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic left_live;
        logic right_live;
        if (i == 0) begin : g_first
            assign left_live = 1'b1;
        end else begin : g_mid_l
            assign left_live = cell_live[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_live = 1'b0;
        end else begin : g_mid_r
            assign right_live = cell_live[i+1];
        end
        rsss_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .sel        (sel_idx == IW'(i)),
            .left_live  (left_live),
            .right_live (right_live),
            .live       (cell_live[i]),
            .hit        (cell_hit[i]),
            .rd_word    (cell_rd[i])
        );
    end

    rsss_rem #(
        .CW (CW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lfsr_stepped),
        .divisor  (member_count_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Stored values are distinct, so at most one hit flag is set.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        rd_or   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_hit[i]) begin
                hit_any = 1'b1;
                hit_idx = hit_idx | IW'(i);
            end
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (req_t'(s_tuser))
                        REQ_INSERT: state_next = S_MATCH;
                        REQ_REMOVE: state_next = S_MATCH;
                        REQ_RANDOM: state_next = set_empty ? S_RESP : S_MOD;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_MATCH:  state_next = S_FIND;
            S_FIND:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (req_reg == REQ_REMOVE && found_reg) begin
                    state_next = S_RDLAST;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RDLAST: state_next = S_GATHER;
            S_GATHER: state_next = (req_reg == REQ_REMOVE) ? S_MOVE : S_RESP;
            S_MOVE:   state_next = S_RESP;
            S_MOD:    state_next = div_busy ? S_MOD : S_RDPICK;
            S_RDPICK: state_next = S_GATHER;
            S_RESP:   state_next = out_load ? S_IDLE : S_RESP;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready          = (state_reg == S_IDLE);
        div_start         = 1'b0;
        sel_idx           = idx_reg;
        cell_ctrl.cmd     = CELL_HOLD;
        cell_ctrl.query   = query_reg;
        cell_ctrl.wr_data = rd_data_reg;
        case (state_reg)
            S_IDLE: begin
                div_start = s_accept && (req_t'(s_tuser) == REQ_RANDOM) && !set_empty;
            end
            S_DECIDE: begin
                if (req_reg == REQ_INSERT && !found_reg && !set_full) begin
                    cell_ctrl.cmd     = CELL_APPEND;
                    cell_ctrl.wr_data = query_reg;
                end
            end
            S_RDLAST: cell_ctrl.cmd = CELL_READ_LAST;
            S_MOVE:   cell_ctrl.cmd = CELL_MOVE;
            S_RDPICK: begin
                cell_ctrl.cmd = CELL_READ_SEL;
                sel_idx       = div_rem[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        req_next          = req_reg;
        query_next        = query_reg;
        member_count_next = member_count_reg;
        seed_next         = seed_reg;
        lfsr_next         = lfsr_reg;
        found_next        = found_reg;
        idx_next          = idx_reg;
        rd_data_next      = rd_data_reg;
        res_status_next   = res_status_reg;
        res_picked_next   = res_picked_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_status_next     = m_status_reg;
        m_picked_next     = m_picked_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next        = req_t'(s_tuser);
                    query_next      = s_tdata;
                    res_status_next = ST_DONE;
                    res_picked_next = '0;
                    if (req_t'(s_tuser) == REQ_RANDOM) begin
                        if (set_empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            lfsr_next = lfsr_stepped;
                        end
                    end
                end
            end
            S_FIND: begin
                found_next = hit_any;
                idx_next   = hit_idx;
            end
            S_DECIDE: begin
                if (req_reg == REQ_INSERT) begin
                    if (found_reg) begin
                        res_status_next = ST_MISS;
                    end else if (set_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        member_count_next = member_count_reg + 1'b1;
                    end
                end else if (!found_reg) begin
                    res_status_next = ST_MISS;
                end
            end
            S_GATHER: begin
                rd_data_next = rd_or;
                if (req_reg == REQ_RANDOM) begin
                    res_picked_next = rd_or;
                end
            end
            S_MOVE: begin
                member_count_next = member_count_reg - 1'b1;
            end
            default: begin
            end
        endcase

        if (cfg_wr && paddr[ADDR_W-1:2] == REG_SEED) begin
            seed_next = pwdata;
            lfsr_next = seed_load(pwdata);
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_status_next = res_status_reg;
            m_picked_next = res_picked_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            member_count_reg <= '0;
            seed_reg         <= {{(DATA_W-1){1'b0}}, 1'b1};
            lfsr_reg         <= {{(DATA_W-1){1'b0}}, 1'b1};
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            member_count_reg <= member_count_next;
            seed_reg         <= seed_next;
            lfsr_reg         <= lfsr_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        req_reg        <= req_next;
        query_reg      <= query_next;
        found_reg      <= found_next;
        idx_reg        <= idx_next;
        rd_data_reg    <= rd_data_next;
        res_status_reg <= res_status_next;
        res_picked_reg <= res_picked_next;
        m_status_reg   <= m_status_next;
        m_picked_reg   <= m_picked_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_picked_reg;

    a_count_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (member_count_reg == '0) == !cell_live[0])
        else $error("member count and first live flag disagree");

    a_count_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_live[CAPACITY-1] |-> (member_count_reg == CW'(CAPACITY)))
        else $error("last cell live while count below capacity");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("LFSR has reached the locked zero state");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second request taken while one is in flight");

endmodule

`default_nettype wire
